/* hw/rtl/olm_pkg.sv */
// shared types and defaults of the ordered list manager
`timescale 1ns / 1ps
`default_nettype none

package olm_pkg;

  localparam int unsigned DefCapacity   = 16;
  localparam int unsigned DefValueWidth = 32;

  // request payload layout
  localparam int unsigned OpWidth    = 2;
  localparam int unsigned InValWidth = 32;
  localparam int unsigned PosWidth   = 4;
  localparam int unsigned InDataW    = 40;

  // result payload layout
  localparam int unsigned StatWidth  = 2;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned OutDataW   = 8;

  typedef enum logic [OpWidth-1:0] {
    OP_APPEND  = 2'd0,
    OP_PREPEND = 2'd1,
    OP_INSERT  = 2'd2,
    OP_DELETE  = 2'd3
  } op_e;

  typedef enum logic [StatWidth-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_WALK,
    S_DEL,
    S_LINK,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/olm_ram.sv */
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module olm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/ordered_list_manager.sv */
// ordered list manager: singly linked list of signed values in a fixed node pool
//
// channel   dir  tdata fields (lsb first)                      meaning
// s_axis    in   operation[1:0] value[33:2] position[37:34]     one list request
// m_axis    out  status[1:0] element_count[6:2]                 one result per request
//
// steps: append and prepend take a node off the free head and link it in; insert-after
//   walks to the position node, then takes a node, or stops when the pool runs out; delete
//   walks the list until it finds the value or reaches the end of the list. the single
//   read port of the link memory sets the walk rate of one node per cycle
// reset: no clearing pass; nodes at or above a fill mark are fresh and link to the next
//   index, so the free list needs no initial sweep
// stalls: s_axis_tready_o is high only when idle; a held result waits in its
//   output register until m_axis_tready_i takes it
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_manager #(
  parameter int unsigned CAPACITY    = olm_pkg::DefCapacity,
  parameter int unsigned VALUE_WIDTH = olm_pkg::DefValueWidth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request: operation[1:0], value[33:2], position[37:34], zero pad to 40 bits
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [olm_pkg::InDataW-1:0]   s_axis_tdata_i,
  // result: status[1:0], element_count[6:2], zero pad to 8 bits
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic      [olm_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  // link and count width holds the null code, which is CAPACITY itself
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = $clog2(CAPACITY);
  localparam logic [LW-1:0] Nil = LW'(CAPACITY);

  // request fields
  olm_pkg::op_e                       in_op;
  logic signed [olm_pkg::InValWidth-1:0] in_val;
  logic        [olm_pkg::PosWidth-1:0] in_pos;
  logic        [VALUE_WIDTH-1:0]      in_val_ext;

  assign in_op  = olm_pkg::op_e'(s_axis_tdata_i[1:0]);
  assign in_val = s_axis_tdata_i[33:2];
  assign in_pos = s_axis_tdata_i[37:34];
  // sign extend or truncate to the stored width
  assign in_val_ext = VALUE_WIDTH'(in_val);

  // sequencer and list state
  olm_pkg::state_e  state_q, state_d;
  olm_pkg::op_e     op_q, op_d;
  olm_pkg::status_e status_q, status_d;
  logic [VALUE_WIDTH-1:0]       val_q, val_d;
  logic [olm_pkg::PosWidth-1:0] cnt_q, cnt_d;
  logic [LW-1:0] cur_q, cur_d;          // node under the walk pointer
  logic [LW-1:0] prev_q, prev_d;        // its predecessor, null at the head
  logic [LW-1:0] link_addr_q, link_addr_d;
  logic [LW-1:0] link_data_q, link_data_d;
  logic [LW-1:0] head_q, head_d;
  logic [LW-1:0] tail_q, tail_d;
  logic [LW-1:0] free_head_q, free_head_d;
  logic [LW-1:0] mark_q, mark_d;        // nodes at or above this were never taken
  logic [LW-1:0] length_q, length_d;

  // memory ports
  logic                   lk_we;
  logic [LW-1:0]          lk_waddr;
  logic [LW-1:0]          lk_wdata;
  logic [LW-1:0]          lk_rdata;
  logic                   vl_we;
  logic [VALUE_WIDTH-1:0] vl_rdata;
  logic [LW-1:0]          rd_addr;

  // next free node after taking the one at the free head
  logic          fresh;
  logic [LW-1:0] take_next;

  assign fresh     = (free_head_q >= mark_q);
  assign take_next = fresh ? (free_head_q + LW'(1)) : lk_rdata;

  olm_ram #(
    .WIDTH (LW),
    .DEPTH (CAPACITY)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr[PW-1:0]),
    .wdata_i (lk_wdata),
    .raddr_i (rd_addr[PW-1:0]),
    .rdata_o (lk_rdata)
  );

  olm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_values (
    .clk_i   (clk_i),
    .we_i    (vl_we),
    .waddr_i (free_head_q[PW-1:0]),
    .wdata_i (val_q),
    .raddr_i (rd_addr[PW-1:0]),
    .rdata_o (vl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olm_pkg::S_IDLE;
      head_q      <= Nil;
      tail_q      <= Nil;
      free_head_q <= '0;
      mark_q      <= '0;
      length_q    <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_head_q <= free_head_d;
      mark_q      <= mark_d;
      length_q    <= length_d;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    status_q    <= status_d;
    val_q       <= val_d;
    cnt_q       <= cnt_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    link_addr_q <= link_addr_d;
    link_data_q <= link_data_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    status_d    = status_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    link_addr_d = link_addr_q;
    link_data_d = link_data_q;
    head_d      = head_q;
    tail_d      = tail_q;
    free_head_d = free_head_q;
    mark_d      = mark_q;
    length_d    = length_q;
    lk_we       = 1'b0;
    lk_waddr    = link_addr_q;
    lk_wdata    = link_data_q;
    vl_we       = 1'b0;
    rd_addr     = head_q;

    case (state_q)
      olm_pkg::S_IDLE: begin
        // appends and prepends prefetch the free head link, walks start at the head
        if (in_op == olm_pkg::OP_APPEND || in_op == olm_pkg::OP_PREPEND) begin
          rd_addr = free_head_q;
        end
        if (s_axis_tvalid_i) begin
          op_d     = in_op;
          val_d    = in_val_ext;
          cnt_d    = in_pos;
          cur_d    = head_q;
          prev_d   = Nil;
          status_d = olm_pkg::ST_DONE;
          case (in_op)
            olm_pkg::OP_APPEND, olm_pkg::OP_PREPEND: begin
              if (free_head_q == Nil) begin
                status_d = olm_pkg::ST_FULL;
                state_d  = olm_pkg::S_RESP;
              end else begin
                state_d = olm_pkg::S_TAKE;
              end
            end
            olm_pkg::OP_INSERT: begin
              // the position check comes before the pool check
              if (32'(in_pos) >= 32'(length_q)) begin
                status_d = olm_pkg::ST_RANGE;
                state_d  = olm_pkg::S_RESP;
              end else begin
                state_d = olm_pkg::S_WALK;
              end
            end
            default: begin
              if (head_q == Nil) begin
                status_d = olm_pkg::ST_MISSING;
                state_d  = olm_pkg::S_RESP;
              end else begin
                state_d = olm_pkg::S_DEL;
              end
            end
          endcase
        end
      end

      olm_pkg::S_WALK: begin
        // link of cur_q is on the read port this cycle
        if (cnt_q == '0) begin
          link_addr_d = cur_q;
          link_data_d = lk_rdata;
          rd_addr     = free_head_q;
          if (free_head_q == Nil) begin
            status_d = olm_pkg::ST_FULL;
            state_d  = olm_pkg::S_RESP;
          end else begin
            state_d = olm_pkg::S_TAKE;
          end
        end else begin
          cnt_d   = cnt_q - olm_pkg::PosWidth'(1);
          cur_d   = lk_rdata;
          rd_addr = lk_rdata;
        end
      end

      olm_pkg::S_TAKE: begin
        // pop the free head, fill it and link it in
        vl_we       = 1'b1;
        lk_we       = 1'b1;
        lk_waddr    = free_head_q;
        lk_wdata    = Nil;
        free_head_d = take_next;
        if (fresh) begin
          mark_d = mark_q + LW'(1);
        end
        length_d    = length_q + LW'(1);
        link_data_d = free_head_q;
        state_d     = olm_pkg::S_RESP;
        case (op_q)
          olm_pkg::OP_APPEND: begin
            tail_d = free_head_q;
            if (head_q == Nil) begin
              head_d = free_head_q;
            end else begin
              link_addr_d = tail_q;
              state_d     = olm_pkg::S_LINK;
            end
          end
          olm_pkg::OP_PREPEND: begin
            lk_wdata = head_q;
            head_d   = free_head_q;
            if (head_q == Nil) begin
              tail_d = free_head_q;
            end
          end
          olm_pkg::OP_INSERT: begin
            lk_wdata = link_data_q;
            if (tail_q == link_addr_q) begin
              tail_d = free_head_q;
            end
            state_d = olm_pkg::S_LINK;
          end
          default: begin
            state_d = olm_pkg::S_RESP;
          end
        endcase
      end

      olm_pkg::S_DEL: begin
        // value and link of cur_q are on the read ports this cycle
        if (vl_rdata == val_q) begin
          free_head_d = cur_q;
          length_d    = length_q - LW'(1);
          if (tail_q == cur_q) begin
            tail_d = prev_q;
          end
          lk_we = 1'b1;
          if (prev_q == Nil) begin
            head_d   = lk_rdata;
            lk_waddr = cur_q;
            lk_wdata = free_head_q;
            state_d  = olm_pkg::S_RESP;
          end else begin
            // unlink now, push the freed node on the next cycle
            lk_waddr    = prev_q;
            lk_wdata    = lk_rdata;
            link_addr_d = cur_q;
            link_data_d = free_head_q;
            state_d     = olm_pkg::S_LINK;
          end
        end else if (lk_rdata == Nil) begin
          status_d = olm_pkg::ST_MISSING;
          state_d  = olm_pkg::S_RESP;
        end else begin
          prev_d  = cur_q;
          cur_d   = lk_rdata;
          rd_addr = lk_rdata;
        end
      end

      olm_pkg::S_LINK: begin
        lk_we   = 1'b1;
        state_d = olm_pkg::S_RESP;
      end

      olm_pkg::S_RESP: begin
        if (m_axis_tready_i) begin
          state_d = olm_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = olm_pkg::S_IDLE;
      end
    endcase
  end

  // count masked to the result field width
  logic [LW+olm_pkg::CountWidth-1:0] count_ext;
  assign count_ext = {{olm_pkg::CountWidth{1'b0}}, length_q};

  assign s_axis_tready_o = (state_q == olm_pkg::S_IDLE);
  assign m_axis_tvalid_o = (state_q == olm_pkg::S_RESP);
  assign m_axis_tdata_o  = {1'b0, count_ext[olm_pkg::CountWidth-1:0], status_q};

  // pool and list bookkeeping stay consistent
  a_full_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_head_q == Nil) == (length_q == Nil))
    else $error("free list empty does not match a full list");

  a_empty_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == Nil) == (length_q == '0))
    else $error("head null does not match a zero count");

  a_tail_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == Nil) == (tail_q == Nil))
    else $error("head and tail disagree on an empty list");

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (length_q <= Nil) && (mark_q <= Nil) && (length_q <= mark_q))
    else $error("count or fill mark out of range");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q != olm_pkg::S_IDLE))
    else $error("request taken but sequencer stayed idle");

endmodule

`default_nettype wire

/* sim/list_result_checker.sv */
// result checker of the ordered list manager: models the list and compares every result
`timescale 1ns / 1ps

module list_result_checker #(
  parameter int unsigned CAPACITY = olm_pkg::DefCapacity
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel: operation, value, position from the lowest bit up
  input  logic                         req_valid_i,
  input  logic                         req_ready_i,
  input  logic [olm_pkg::InDataW-1:0]  req_data_i,
  // result channel: status, element_count from the lowest bit up
  input  logic                         res_valid_i,
  input  logic                         res_ready_i,
  input  logic [olm_pkg::OutDataW-1:0] res_data_i,
  output int                           fail_count_o,
  output int                           outstanding_o
);

  import olm_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY + 1);
  localparam logic [IdxW-1:0] NIL = IdxW'(CAPACITY);

  typedef struct packed {
    status_e                status;
    logic [CountWidth-1:0]  count;
  } list_result_t;

  list_result_t pending_results[$];
  list_result_t oldest;
  status_e      req_status;
  status_e      got_status;
  logic [CountWidth-1:0] got_count;

  // model of the node pool
  logic [InValWidth-1:0] node_val  [CAPACITY];
  logic [IdxW-1:0]       node_next [CAPACITY];
  logic [IdxW-1:0]       head_q;
  logic [IdxW-1:0]       tail_q;
  logic [IdxW-1:0]       free_q;
  logic [CountWidth-1:0] count_q;

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
  end

  // apply one request to the model list and return its status
  function automatic status_e apply_request(op_e op, logic [InValWidth-1:0] val,
                                            logic [PosWidth-1:0] pos);
    logic [IdxW-1:0] node;
    logic [IdxW-1:0] cur;
    logic [IdxW-1:0] prev;
    int unsigned     step;
    status_e         st;
    st = ST_DONE;
    case (op)
      OP_APPEND, OP_PREPEND: begin
        if (free_q == NIL) begin
          st = ST_FULL;
        end else begin
          node = free_q;
          free_q = node_next[node];
          node_val[node] = val;
          if (op == OP_APPEND) begin
            node_next[node] = NIL;
            if (head_q == NIL) head_q = node;
            else node_next[tail_q] = node;
            tail_q = node;
          end else begin
            node_next[node] = head_q;
            if (head_q == NIL) tail_q = node;
            head_q = node;
          end
          count_q++;
        end
      end
      OP_INSERT: begin
        // position is checked before the pool
        if (pos >= count_q) begin
          st = ST_RANGE;
        end else if (free_q == NIL) begin
          st = ST_FULL;
        end else begin
          cur = head_q;
          for (step = 0; step < pos; step++) cur = node_next[cur];
          node = free_q;
          free_q = node_next[node];
          node_val[node] = val;
          node_next[node] = node_next[cur];
          node_next[cur] = node;
          if (tail_q == cur) tail_q = node;
          count_q++;
        end
      end
      default: begin
        st = ST_MISSING;
        prev = NIL;
        cur = head_q;
        for (step = 0; step < CAPACITY && cur != NIL && st == ST_MISSING; step++) begin
          if (node_val[cur] == val) begin
            if (prev == NIL) head_q = node_next[cur];
            else node_next[prev] = node_next[cur];
            if (tail_q == cur) tail_q = prev;
            // freed node goes on top of the free list
            node_next[cur] = free_q;
            free_q = cur;
            count_q--;
            st = ST_DONE;
          end else begin
            prev = cur;
            cur = node_next[cur];
          end
        end
      end
    endcase
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < CAPACITY; i++) begin
        node_val[i]  = '0;
        node_next[i] = IdxW'(i + 1);
      end
      head_q  = NIL;
      tail_q  = NIL;
      free_q  = '0;
      count_q = '0;
      pending_results.delete();
      outstanding_o = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got_status = status_e'(res_data_i[StatWidth-1:0]);
        got_count  = res_data_i[StatWidth +: CountWidth];
        if (pending_results.size() == 0) begin
          $error("result with no request waiting: status %0d element_count %0d",
                 got_status, got_count);
          fail_count_o++;
        end else begin
          oldest = pending_results.pop_front();
          if (got_status !== oldest.status) begin
            $error("status: expected %0d actual %0d", oldest.status, got_status);
            fail_count_o++;
          end
          if (got_count !== oldest.count) begin
            $error("element_count: expected %0d actual %0d", oldest.count, got_count);
            fail_count_o++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        req_status = apply_request(op_e'(req_data_i[OpWidth-1:0]),
                                   req_data_i[OpWidth +: InValWidth],
                                   req_data_i[OpWidth+InValWidth +: PosWidth]);
        pending_results.push_back('{status: req_status, count: count_q});
      end
      outstanding_o = pending_results.size();
    end
  end

endmodule

/* sim/testbench.sv */
// top of the ordered list manager testbench: request stimulus, result stalls and verdict
`timescale 1ns / 1ps

module testbench;

  import olm_pkg::*;

  localparam int unsigned PoolSize    = 12;
  localparam int unsigned PhaseItems  = 363;
  localparam int unsigned BiasRun     = 48;
  localparam int unsigned HoldCycles  = 400;

  // clock and the one reset at the start
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request side, driven at the falling edge
  logic                s_valid = 1'b0;
  wire                 s_ready;
  logic [InDataW-1:0]  s_data  = '0;

  // result side
  wire                 m_valid;
  logic                m_ready = 1'b0;
  wire [OutDataW-1:0]  m_data;

  int fail_count;
  int outstanding;

  // idling knobs for the current phase, in percent
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;

  // long hold-off of the result side, counted by the receiver process
  int unsigned hold_left    = 0;
  bit          hold_trigger = 1'b0;

  // values reused across requests so that deletes find their targets
  logic [InValWidth-1:0] value_pool [PoolSize];

  always #6 clk_i = ~clk_i;

  ordered_list_manager u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  // watches both channels, predicts each result and compares
  list_result_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_valid),
    .req_ready_i   (s_ready),
    .req_data_i    (s_data),
    .res_valid_i   (m_valid),
    .res_ready_i   (m_ready),
    .res_data_i    (m_data),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // receiver: random stalls, or a long hold-off once asked for
  always @(negedge clk_i) begin
    if (hold_trigger) begin
      hold_left    = HoldCycles;
      hold_trigger = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // run limit, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // offer one request and wait until the block takes it
  task automatic send_request(op_e op, logic [InValWidth-1:0] val, logic [PosWidth-1:0] pos);
    @(negedge clk_i);
    // sender gaps, one cycle each
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    // tdata: operation, value, position from the lowest bit up, zero pad on top
    s_data  <= {{(InDataW - OpWidth - InValWidth - PosWidth){1'b0}}, pos, val, op};
    do @(posedge clk_i); while (!s_ready);
  endtask

  // mostly a pooled value, sometimes a fresh random one
  function automatic logic [InValWidth-1:0] pick_value();
    if ($urandom_range(0, 99) < 75) return value_pool[$urandom_range(0, PoolSize - 1)];
    return $urandom;
  endfunction

  initial begin
    int unsigned     phase;
    int unsigned     n;
    int unsigned     r;
    bit              grow;
    op_e             op;
    logic [PosWidth-1:0] pos;

    grow = 1'b0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    for (int unsigned i = 4; i < PoolSize; i++) value_pool[i] = $urandom;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty list cases first
    send_request(OP_DELETE, 32'd5, 4'd0);             // delete from empty list
    send_request(OP_INSERT, 32'd9, 4'd0);             // insert into empty list
    send_request(OP_APPEND, 32'h7FFF_FFFF, 4'd0);
    send_request(OP_PREPEND, 32'h8000_0000, 4'd0);
    send_request(OP_INSERT, 32'h0000_0000, 4'd1);     // after the tail, tail moves
    send_request(OP_INSERT, 32'h1234_5678, 4'd3);     // position past the end
    send_request(OP_INSERT, 32'hFFFF_FFFF, 4'd0);
    send_request(OP_DELETE, 32'h8000_0000, 4'd0);     // delete of the head
    send_request(OP_DELETE, 32'h0000_0000, 4'd0);     // delete of the tail
    send_request(OP_DELETE, 32'h0001_2345, 4'd0);     // value not on the list
    // fill the pool to the last node
    for (int unsigned i = 0; i < 14; i++) begin
      send_request((i % 2) ? OP_PREPEND : OP_APPEND,
                   ((i % 2) ? 32'hAAAA_0000 : 32'h5555_FFFF) ^ i, 4'(i));
    end
    // pool full on every inserting operation
    send_request(OP_APPEND, 32'h0F0F_0F0F, 4'd0);
    send_request(OP_PREPEND, 32'hF0F0_F0F0, 4'd0);
    send_request(OP_INSERT, 32'h3C3C_3C3C, 4'd15);   // valid position, no free node

    // random part: four idling phases, grow and shrink runs within each
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 48; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 48; end
        default: begin src_idle_pct = 10; snk_stall_pct = 10; end
      endcase
      for (n = 0; n < PhaseItems; n++) begin
        if (n % BiasRun == 0) begin
          grow = ~grow;
          value_pool[$urandom_range(4, PoolSize - 1)] = $urandom;
        end
        // result side holds off while requests keep coming, block backs up
        if (phase == 0 && n == 120) hold_trigger = 1'b1;
        r = $urandom_range(0, 99);
        if (grow) begin
          op = (r < 35) ? OP_APPEND : (r < 60) ? OP_PREPEND : (r < 90) ? OP_INSERT : OP_DELETE;
        end else begin
          op = (r < 12) ? OP_APPEND : (r < 20) ? OP_PREPEND : (r < 30) ? OP_INSERT : OP_DELETE;
        end
        pos = $urandom_range(0, 1) ? PosWidth'($urandom_range(0, 15))
                                   : PosWidth'($urandom_range(0, 4));
        send_request(op, pick_value(), pos);
      end
    end

    @(negedge clk_i);
    s_valid <= 1'b0;

    // drain: every request answered, then a wait for stray results
    wait (outstanding == 0);
    repeat (40) @(posedge clk_i);

    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
